// File: rtl/core/lswc_pkg.sv
`default_nettype none
package lswc_pkg;

  // Coordinate and arithmetic widths.
  localparam int CW = 16;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int ITERS = 8;
  localparam int IDX_W = 3;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] diff_t;
  typedef logic [DW-1:0] mag_t;
  typedef logic [3:0] ocode_t;
  typedef logic [IDX_W-1:0] cfg_idx_t;

  localparam ocode_t OC_LEFT  = 4'b0001;
  localparam ocode_t OC_RIGHT = 4'b0010;
  localparam ocode_t OC_BELOW = 4'b0100;
  localparam ocode_t OC_ABOVE = 4'b1000;

  localparam cfg_idx_t REG_LEFT   = 3'd0;
  localparam cfg_idx_t REG_RIGHT  = 3'd1;
  localparam cfg_idx_t REG_BOTTOM = 3'd2;
  localparam cfg_idx_t REG_TOP    = 3'd3;

  typedef struct packed {
    coord_t left;
    coord_t right;
    coord_t bottom;
    coord_t top;
  } win_t;

  // One segment as it travels down the pipeline.
  typedef struct packed {
    logic   valid;
    logic   done;
    logic   accept;
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
  } seg_t;

  // Pending endpoint move of one pass.
  typedef struct packed {
    logic   move_end;
    logic   vert;
    coord_t edge_v;
    coord_t base;
    logic   neg;
  } move_t;

  function automatic ocode_t outcode(coord_t x, coord_t y, win_t w);
    ocode_t c;
    c = '0;
    if (x < w.left)   c = c | OC_LEFT;
    if (x > w.right)  c = c | OC_RIGHT;
    if (y < w.bottom) c = c | OC_BELOW;
    if (y > w.top)    c = c | OC_ABOVE;
    return c;
  endfunction

  function automatic diff_t sdiff(coord_t a, coord_t b);
    diff_t r;
    r = $signed({a[CW-1], a}) - $signed({b[CW-1], b});
    return r;
  endfunction

  function automatic mag_t dmag(diff_t v);
    mag_t m;
    m = v[DW-1] ? mag_t'(-v) : mag_t'(v);
    return m;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/line_segment_window_clipper.sv
// Channel   Ports                                   Handshake
// input     in_start_x/y, in_end_x/y                start, busy
// result    out_visible, out_clipped_*              out_valid strobe
// config    cfg_index, cfg_data                     cfg_valid, cfg_ready
//
// One segment may start in every cycle; busy is always low.
// The pipeline has eight clipping passes of 20 stages each (setup,
// multiply, 17 divider steps, update) plus the output register.
// Reset is synchronous and active low; it clears the window registers to
// 0/639/0/479 and empties the pipeline. The receiver cannot stall.
`default_nettype none
module line_segment_window_clipper import lswc_pkg::*; (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             start,
  output logic            busy,
  input  wire  [CW-1:0]   in_start_x,
  input  wire  [CW-1:0]   in_start_y,
  input  wire  [CW-1:0]   in_end_x,
  input  wire  [CW-1:0]   in_end_y,
  output logic            out_valid,
  output logic            out_visible,
  output logic [CW-1:0]   out_clipped_start_x,
  output logic [CW-1:0]   out_clipped_start_y,
  output logic [CW-1:0]   out_clipped_end_x,
  output logic [CW-1:0]   out_clipped_end_y,
  input  wire             cfg_valid,
  output logic            cfg_ready,
  input  wire  [IDX_W-1:0] cfg_index,
  input  wire  [CW-1:0]   cfg_data
);

  win_t win_r;
  seg_t seg_in;
  seg_t chain [0:ITERS];
  logic out_valid_r, out_visible_r;
  coord_t osx_r, osy_r, oex_r, oey_r;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  // Window registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r.left   <= CW'(0);
      win_r.right  <= CW'(639);
      win_r.bottom <= CW'(0);
      win_r.top    <= CW'(479);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LEFT:   win_r.left   <= cfg_data;
        REG_RIGHT:  win_r.right  <= cfg_data;
        REG_BOTTOM: win_r.bottom <= cfg_data;
        REG_TOP:    win_r.top    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Incoming word enters the first pass.
  always_comb begin
    seg_in.valid  = start && !busy;
    seg_in.done   = 1'b0;
    seg_in.accept = 1'b0;
    seg_in.x0 = in_start_x;
    seg_in.y0 = in_start_y;
    seg_in.x1 = in_end_x;
    seg_in.y1 = in_end_y;
  end

  assign chain[0] = seg_in;

  for (genvar i = 0; i < ITERS; i++) begin : g_pass
    lswc_iter u_iter (
      .clk   (clk),
      .rst_n (rst_n),
      .win   (win_r),
      .seg_i (chain[i]),
      .seg_o (chain[i+1])
    );
  end

  // Result register; a segment not accepted within the eight passes is rejected.
  logic vis;
  assign vis = chain[ITERS].done && chain[ITERS].accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= chain[ITERS].valid;
    end
    out_visible_r <= vis;
    osx_r <= vis ? chain[ITERS].x0 : '0;
    osy_r <= vis ? chain[ITERS].y0 : '0;
    oex_r <= vis ? chain[ITERS].x1 : '0;
    oey_r <= vis ? chain[ITERS].y1 : '0;
  end

  assign out_valid = out_valid_r;
  assign out_visible = out_visible_r;
  assign out_clipped_start_x = osx_r;
  assign out_clipped_start_y = osy_r;
  assign out_clipped_end_x = oex_r;
  assign out_clipped_end_y = oey_r;

  // A visible result lies inside the window.
  a_start_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_visible) |-> (outcode(osx_r, osy_r, win_r) == '0))
    else $error("clipped start point outside window");

  a_end_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_visible) |-> (outcode(oex_r, oey_r, win_r) == '0))
    else $error("clipped end point outside window");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_visible) |->
      (osx_r == '0 && osy_r == '0 && oex_r == '0 && oey_r == '0))
    else $error("rejected segment carries nonzero coordinates");

endmodule
`default_nettype wire

// File: rtl/core/lswc_iter.sv
`default_nettype none
module lswc_iter import lswc_pkg::*; (
  input  wire  clk,
  input  wire  rst_n,
  input  win_t win,
  input  seg_t seg_i,
  output seg_t seg_o
);

  ocode_t c0, c1, csel;
  diff_t  num, off, den;
  seg_t   seg_a_nxt;
  move_t  mv_a_nxt;

  seg_t  seg_a_r, seg_m_r, seg_o_r;
  move_t mv_a_r, mv_m_r;
  mag_t  mn_a_r, mo_a_r, md_a_r, md_m_r;
  logic [PW-1:0] prod_r;

  // Outcodes, trivial accept/reject and choice of the clipping edge.
  always_comb begin
    c0 = outcode(seg_i.x0, seg_i.y0, win);
    c1 = outcode(seg_i.x1, seg_i.y1, win);
    csel = (c0 != '0) ? c0 : c1;
    seg_a_nxt = seg_i;
    mv_a_nxt.move_end = (c0 == '0);
    if ((csel & OC_LEFT) != '0) begin
      mv_a_nxt.vert = 1'b1;
      mv_a_nxt.edge_v = win.left;
      mv_a_nxt.base = seg_i.y0;
      num = sdiff(seg_i.y1, seg_i.y0);
      off = sdiff(win.left, seg_i.x0);
      den = sdiff(seg_i.x1, seg_i.x0);
    end else if ((csel & OC_RIGHT) != '0) begin
      mv_a_nxt.vert = 1'b1;
      mv_a_nxt.edge_v = win.right;
      mv_a_nxt.base = seg_i.y0;
      num = sdiff(seg_i.y1, seg_i.y0);
      off = sdiff(win.right, seg_i.x0);
      den = sdiff(seg_i.x1, seg_i.x0);
    end else if ((csel & OC_BELOW) != '0) begin
      mv_a_nxt.vert = 1'b0;
      mv_a_nxt.edge_v = win.bottom;
      mv_a_nxt.base = seg_i.x0;
      num = sdiff(seg_i.x1, seg_i.x0);
      off = sdiff(win.bottom, seg_i.y0);
      den = sdiff(seg_i.y1, seg_i.y0);
    end else begin
      mv_a_nxt.vert = 1'b0;
      mv_a_nxt.edge_v = win.top;
      mv_a_nxt.base = seg_i.x0;
      num = sdiff(seg_i.x1, seg_i.x0);
      off = sdiff(win.top, seg_i.y0);
      den = sdiff(seg_i.y1, seg_i.y0);
    end
    mv_a_nxt.neg = (num[DW-1] ^ off[DW-1]) ^ den[DW-1];
    if (!seg_i.done) begin
      if ((c0 | c1) == '0) begin
        seg_a_nxt.done = 1'b1;
        seg_a_nxt.accept = 1'b1;
      end else if ((c0 & c1) != '0) begin
        seg_a_nxt.done = 1'b1;
        seg_a_nxt.accept = 1'b0;
      end
    end
  end

  // Setup stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_a_r.valid <= 1'b0;
    end else begin
      seg_a_r <= seg_a_nxt;
    end
    mv_a_r <= mv_a_nxt;
    mn_a_r <= dmag(num);
    mo_a_r <= dmag(off);
    md_a_r <= dmag(den);
  end

  // Multiply stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_m_r.valid <= 1'b0;
    end else begin
      seg_m_r <= seg_a_r;
    end
    mv_m_r <= mv_a_r;
    md_m_r <= md_a_r;
    prod_r <= PW'(mn_a_r) * PW'(mo_a_r);
  end

  // Restoring divider, one quotient bit per stage. The product stays
  // below the divisor times two to the DW, so the high half starts as remainder.
  seg_t          seg_d [0:DW];
  move_t         mv_d  [0:DW];
  mag_t          den_d [0:DW];
  mag_t          rem_d [0:DW];
  mag_t          lo_d  [0:DW];
  mag_t          quo_d [0:DW];

  assign seg_d[0] = seg_m_r;
  assign mv_d[0]  = mv_m_r;
  assign den_d[0] = md_m_r;
  assign rem_d[0] = prod_r[PW-1:DW];
  assign lo_d[0]  = prod_r[DW-1:0];
  assign quo_d[0] = '0;

  for (genvar k = 0; k < DW; k++) begin : g_div
    logic [DW:0] trial;
    logic        ge;
    assign trial = {rem_d[k], lo_d[k][DW-1]};
    assign ge = (trial >= {1'b0, den_d[k]});
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        seg_d[k+1].valid <= 1'b0;
      end else begin
        seg_d[k+1] <= seg_d[k];
      end
      mv_d[k+1]  <= mv_d[k];
      den_d[k+1] <= den_d[k];
      rem_d[k+1] <= ge ? DW'(trial - {1'b0, den_d[k]}) : trial[DW-1:0];
      lo_d[k+1]  <= {lo_d[k][DW-2:0], 1'b0};
      quo_d[k+1] <= {quo_d[k][DW-2:0], ge};
    end
  end

  // Update stage: move the chosen endpoint onto the edge.
  seg_t  seg_o_nxt;
  diff_t icoord;
  coord_t ncoord;

  always_comb begin
    icoord = mv_d[DW].neg ? ($signed({mv_d[DW].base[CW-1], mv_d[DW].base})
                             - $signed(quo_d[DW]))
                          : ($signed({mv_d[DW].base[CW-1], mv_d[DW].base})
                             + $signed(quo_d[DW]));
    ncoord = icoord[CW-1:0];
    seg_o_nxt = seg_d[DW];
    if (!seg_d[DW].done) begin
      if (mv_d[DW].move_end) begin
        seg_o_nxt.x1 = mv_d[DW].vert ? mv_d[DW].edge_v : ncoord;
        seg_o_nxt.y1 = mv_d[DW].vert ? ncoord : mv_d[DW].edge_v;
      end else begin
        seg_o_nxt.x0 = mv_d[DW].vert ? mv_d[DW].edge_v : ncoord;
        seg_o_nxt.y0 = mv_d[DW].vert ? ncoord : mv_d[DW].edge_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_o_r.valid <= 1'b0;
    end else begin
      seg_o_r <= seg_o_nxt;
    end
  end

  assign seg_o = seg_o_r;

endmodule
`default_nettype wire

// File: test/line_segment_window_clipper_tb.sv
`timescale 1ns / 1ps
module line_segment_window_clipper_tb;
  import lswc_pkg::*;

  localparam int       DRAIN_CYCLES = 200;
  localparam int       STALL_LIMIT  = 4000;
  localparam cfg_idx_t REG_UNUSED   = 3'd5;

  typedef struct {
    logic   visible;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
  } clip_result_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           start = 1'b0;
  logic           busy;
  logic [CW-1:0]  in_start_x = '0;
  logic [CW-1:0]  in_start_y = '0;
  logic [CW-1:0]  in_end_x = '0;
  logic [CW-1:0]  in_end_y = '0;
  logic           out_valid;
  logic           out_visible;
  logic [CW-1:0]  out_clipped_start_x;
  logic [CW-1:0]  out_clipped_start_y;
  logic [CW-1:0]  out_clipped_end_x;
  logic [CW-1:0]  out_clipped_end_y;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CW-1:0]  cfg_data = '0;

  // Local copy of the window registers.
  coord_t win_left = 16'sd0;
  coord_t win_right = 16'sd639;
  coord_t win_bottom = 16'sd0;
  coord_t win_top = 16'sd479;

  clip_result_t clipped_q[$];
  int           error_count = 0;
  int           idle_pct = 0;
  int           stall_cycles = 0;

  always #6 clk = ~clk;

  line_segment_window_clipper i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_start_x(in_start_x), .in_start_y(in_start_y),
    .in_end_x(in_end_x), .in_end_y(in_end_y),
    .out_valid(out_valid), .out_visible(out_visible),
    .out_clipped_start_x(out_clipped_start_x), .out_clipped_start_y(out_clipped_start_y),
    .out_clipped_end_x(out_clipped_end_x), .out_clipped_end_y(out_clipped_end_y),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic ocode_t region_code(longint x, longint y);
    ocode_t c;
    c = '0;
    if (x < win_left)   c = c | OC_LEFT;
    if (x > win_right)  c = c | OC_RIGHT;
    if (y < win_bottom) c = c | OC_BELOW;
    if (y > win_top)    c = c | OC_ABOVE;
    return c;
  endfunction

  // Cohen-Sutherland loop with exact products and division toward zero.
  function automatic clip_result_t clip_segment(coord_t ax, coord_t ay, coord_t bx, coord_t by);
    longint x0, y0, x1, y1, nx, ny;
    ocode_t c0, c1, c;
    bit acc;
    clip_result_t res;
    x0 = ax; y0 = ay; x1 = bx; y1 = by;
    acc = 0;
    for (int i = 0; i < ITERS; i++) begin
      c0 = region_code(x0, y0);
      c1 = region_code(x1, y1);
      if ((c0 | c1) == '0) begin
        acc = 1;
        break;
      end
      if ((c0 & c1) != '0) break;
      c = (c0 != '0) ? c0 : c1;
      if ((c & OC_LEFT) != '0) begin
        nx = win_left;
        ny = y0 + (y1 - y0) * (nx - x0) / (x1 - x0);
      end else if ((c & OC_RIGHT) != '0) begin
        nx = win_right;
        ny = y0 + (y1 - y0) * (nx - x0) / (x1 - x0);
      end else if ((c & OC_BELOW) != '0) begin
        ny = win_bottom;
        nx = x0 + (x1 - x0) * (ny - y0) / (y1 - y0);
      end else begin
        ny = win_top;
        nx = x0 + (x1 - x0) * (ny - y0) / (y1 - y0);
      end
      if (c0 != '0) begin
        x0 = nx; y0 = ny;
      end else begin
        x1 = nx; y1 = ny;
      end
    end
    res.visible = acc;
    res.sx = acc ? coord_t'(x0) : '0;
    res.sy = acc ? coord_t'(y0) : '0;
    res.ex = acc ? coord_t'(x1) : '0;
    res.ey = acc ? coord_t'(y1) : '0;
    return res;
  endfunction

  // Send one segment word; start stays high across back-to-back words.
  task automatic send_segment(coord_t ax, coord_t ay, coord_t bx, coord_t by);
    logic b;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_start_x <= ax; in_start_y <= ay;
    in_end_x <= bx; in_end_y <= by;
    do begin
      @(negedge clk);
      b = busy;
      @(posedge clk);
    end while (b);
    clipped_q.push_back(clip_segment(ax, ay, bx, by));
  endtask

  task automatic idle_input();
    start <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every expected word has arrived, plus some slack.
  task automatic wait_drained();
    idle_input();
    while (clipped_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, coord_t value);
    logic r;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do begin
      @(negedge clk);
      r = cfg_ready;
      @(posedge clk);
    end while (!r);
    cfg_valid <= 1'b0;
    case (idx)
      REG_LEFT:   win_left = value;
      REG_RIGHT:  win_right = value;
      REG_BOTTOM: win_bottom = value;
      REG_TOP:    win_top = value;
      default: ;
    endcase
  endtask

  task automatic set_window(coord_t l, coord_t r, coord_t b, coord_t t);
    wait_drained();
    write_reg(REG_LEFT, l);
    write_reg(REG_RIGHT, r);
    write_reg(REG_BOTTOM, b);
    write_reg(REG_TOP, t);
  endtask

  // A coordinate near the span lo..hi, sometimes anywhere.
  function automatic coord_t near_coord(coord_t lo, coord_t hi);
    longint v, a, z;
    if ($urandom_range(4) == 0) return coord_t'($urandom);
    a = (lo < hi) ? lo : hi;
    z = (lo < hi) ? hi : lo;
    v = a - 64 + longint'($urandom_range(int'(z - a + 128)));
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return coord_t'(v);
  endfunction

  // Crossing of every edge, corners, rejects and degenerate lines.
  task automatic test_directed_cases();
    send_segment(10, 10, 600, 400);
    send_segment(-50, 100, -10, 300);
    send_segment(-100, 240, 700, 240);
    send_segment(320, -100, 320, 600);
    send_segment(-32768, -32768, 32767, 32767);
    send_segment(32767, -32768, -32768, 32767);
    send_segment(-20, 500, 700, -30);
    send_segment(-10, 470, 30, 520);
    send_segment(600, -10, 700, 20);
    send_segment(0, 0, 639, 479);
    send_segment(-32768, 0, -32768, 479);
    send_segment(32767, 32767, 32767, 32767);
    send_segment(100, 100, 100, 100);
    send_segment(640, 480, -1, -1);
    send_segment(-1, 240, 0, 240);
  endtask

  // Full-range, inverted, single-point windows and an unused index.
  task automatic test_window_extremes();
    set_window(-32768, 32767, -32768, 32767);
    send_segment(-32768, 32767, 32767, -32768);
    send_segment(123, -456, 7, 8);
    set_window(100, -100, 0, 479);
    send_segment(0, 10, 50, 20);
    send_segment(-200, 5, 200, 5);
    set_window(5, 5, 7, 7);
    send_segment(5, 7, 5, 7);
    send_segment(0, 2, 10, 12);
    send_segment(0, 0, 10, 20);
    wait_drained();
    write_reg(REG_UNUSED, 16'sh7fff);
    send_segment(5, 0, 5, 20);
  endtask

  task automatic test_random_phase(int pct, int count);
    coord_t l, r, b, t;
    idle_pct = pct;
    for (int w = 0; w < 4; w++) begin
      l = coord_t'($urandom); r = coord_t'($urandom);
      b = coord_t'($urandom); t = coord_t'($urandom);
      if (w < 3 && l > r) begin l = r; r = coord_t'($urandom); end
      if (w < 3 && (r < l)) r = l;
      if (w < 3 && b > t) begin coord_t s; s = b; b = t; t = s; end
      if (w == 1) begin
        l = -coord_t'($urandom_range(300)); r = l + coord_t'($urandom_range(600));
        b = -coord_t'($urandom_range(300)); t = b + coord_t'($urandom_range(600));
      end
      set_window(l, r, b, t);
      for (int i = 0; i < count / 4; i++) begin
        if (i == count / 8) wait_drained();
        send_segment(near_coord(l, r), near_coord(b, t), near_coord(l, r), near_coord(b, t));
      end
    end
  endtask

  // Check each result word against the oldest prediction.
  always @(negedge clk) begin
    clip_result_t exp_r;
    if (rst_n && out_valid) begin
      if (clipped_q.size() == 0) begin
        $display("%0t: unexpected result word", $time);
        error_count++;
      end else begin
        exp_r = clipped_q.pop_front();
        if (out_visible !== exp_r.visible || out_clipped_start_x !== exp_r.sx ||
            out_clipped_start_y !== exp_r.sy || out_clipped_end_x !== exp_r.ex ||
            out_clipped_end_y !== exp_r.ey) begin
          $display("%0t: expected %b %0d %0d %0d %0d, got %b %0d %0d %0d %0d", $time,
                   exp_r.visible, exp_r.sx, exp_r.sy, exp_r.ex, exp_r.ey, out_visible,
                   $signed(out_clipped_start_x), $signed(out_clipped_start_y),
                   $signed(out_clipped_end_x), $signed(out_clipped_end_y));
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(negedge clk) begin
    if (!rst_n || out_valid || (start && !busy) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else if (stall_cycles >= STALL_LIMIT) begin
      $display("line_segment_window_clipper_tb: errors");
      $finish;
    end else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_window_extremes();
    test_random_phase(20, 400);
    test_random_phase(59, 400);
    test_random_phase(0, 440);
    idle_input();
    while (clipped_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("line_segment_window_clipper_tb: clean");
    else
      $display("line_segment_window_clipper_tb: errors");
    $finish;
  end

endmodule
